// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of the drive mixer.
// Depends on nothing; the user provides clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RCDM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RCDM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rcdm_pkg.sv
// Types, constants and small arithmetic helpers of the drive mixer.
// Used by the core and by its checker; depends on nothing.
package rcdm_pkg;

  // Input commands.
  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_END  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  // Configuration register indexes.
  localparam logic CFG_MAX_RPM = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  // Clamp actions.
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_PICK = 2'd1;
  localparam logic [1:0] ACT_DROP = 2'd2;

  // Switch codes.
  localparam logic [1:0] SW_OFF    = 2'd0;
  localparam logic [1:0] S1_FWD    = 2'd1;
  localparam logic [1:0] S1_REV    = 2'd2;
  localparam logic [1:0] S1_ARM    = 2'd3;
  localparam logic [1:0] S2_LEFT   = 2'd1;
  localparam logic [1:0] S2_RIGHT  = 2'd2;
  localparam logic [1:0] S2_MANUAL = 2'd3;

  // Frame layout and stick ranges.
  localparam int POS_W   = 5;
  localparam int STORE_N = 6;
  localparam int CH_W    = 11;
  localparam int CH_MID  = 1024;
  localparam int CH_LO   = 364;
  localparam int CH_HI   = 1684;

  // Arithmetic constants.
  localparam int DEAD_SMALL = 5;
  localparam int DEAD_FLAT  = 50;
  localparam int STICK_MUL  = 5;
  localparam int STICK_DIV  = 33;
  localparam int FLAT_MUL   = 5;
  localparam int FLAT_DIV   = 100;
  localparam int CURVE_DIV  = 1000;
  localparam int LIFT_DIV   = 8000;
  localparam int LIFT_UP    = 70;
  localparam int PCT_DIV    = 100;
  localparam int GRIP_DEAD  = 70;
  localparam int CLAMP_TRIP = 99;
  localparam int GRIP_LIM   = 800;
  localparam int LIFT_LIM   = 20000;

  // Divider: dividend magnitude bits and divisor bits.
  localparam int MAG_W  = 30;
  localparam int DIVR_W = 16;

  // Curve argument 19v - 900 for positive v, 19v + 900 for negative v.
  function automatic logic signed [15:0] curve_arg(input logic signed [7:0] v);
    logic signed [15:0] v19;
    v19 = 16'(v) * 16'sd19;
    return v[7] ? v19 + 16'sd900 : v19 - 16'sd900;
  endfunction

  // Dead zone, flat band, then the sloped part already divided.
  function automatic logic signed [13:0] shape_sel(input logic signed [7:0] v,
                                                   input logic [9:0] q5,
                                                   input logic signed [30:0] q);
    logic [7:0]         a;
    logic signed [13:0] f;
    a = v[7] ? 8'(-v) : 8'(v);
    f = signed'({4'b0, q5});
    if (a < 8'(DEAD_SMALL)) begin
      return 14'sd0;
    end else if (a < 8'(DEAD_FLAT)) begin
      return v[7] ? -f : f;
    end
    return signed'(q[13:0]);
  endfunction

  function automatic logic [15:0] abs16(input logic signed [15:0] x);
    return x[15] ? 16'(-x) : 16'(x);
  endfunction

  function automatic logic signed [30:0] sat(input logic signed [30:0] x,
                                             input logic signed [30:0] lim);
    if (x > lim) begin
      return lim;
    end else if (x < -lim) begin
      return -lim;
    end
    return x;
  endfunction

endpackage

// File: hdl/rc_frame_to_drive_mixer_core.sv
// Drive mixer core: frame collection, link watch and the bit-serial mixer.
// Depends on rcdm_pkg.
//
//   channel | direction | handshake         | payload
//   in      | input     | in_valid/in_ready | in_command, in_rx_byte
//   out     | output    | out_valid/out_ready | wheel, grip, lift, flags
//   cfg     | input     | cfg_we            | cfg_index, cfg_data
//
// Bytes, ticks and unused commands are each handled in the idle state.
// A frame end on a range error or a tracking switch goes straight to the push. In
// manual mode each arithmetic step runs through the shared multiplier and
// the one-bit-per-cycle restoring divider; a frame end takes 8 steps, 10 in
// arm mode (11 when the lift points up), plus 4 when the wheel peak is
// limited, and then mixes, commits and pushes its result.
// Reset is synchronous; in_ready is low while a frame end is worked on and
// while its result waits for room in the output register.
module rc_frame_to_drive_mixer_core import rcdm_pkg::*; #(
  parameter int FRAME_BYTES = 18
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [13:0] out_wheel0_speed,
  output logic signed [13:0] out_wheel1_speed,
  output logic signed [13:0] out_wheel2_speed,
  output logic signed [13:0] out_wheel3_speed,
  output logic signed [10:0] out_grip_speed,
  output logic signed [15:0] out_lift_speed,
  output logic               out_grip_open,
  output logic [1:0]         out_grip_action,
  output logic               out_track_on,
  output logic               out_track_left,
  output logic               out_track_begin,
  output logic               out_link_up,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int LIMIT_POS = (FRAME_BYTES < 31) ? FRAME_BYTES : 31;
  localparam int CNT_W     = $clog2(MAG_W);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_LOAD, S_DIV, S_WB, S_MIX, S_FIN, S_PUSH
  } state_t;

  typedef enum logic [3:0] {
    ST_S0, ST_S1, ST_S2, ST_S3, ST_Q5, ST_CR, ST_CH, ST_CV,
    ST_LIFT, ST_LIFT70, ST_GRIP, ST_W0, ST_W1, ST_W2, ST_W3
  } step_t;

  state_t state_r;
  step_t  step_r;

  // Configuration and link state.
  logic [12:0]        max_rpm_r;
  logic [15:0]        timeout_r;
  logic [7:0]         store_r [STORE_N];
  logic [POS_W-1:0]   pos_r;
  logic [15:0]        quiet_r;
  logic               link_r;
  logic signed [13:0] held_wheel_r [4];
  logic signed [10:0] held_grip_r;
  logic signed [15:0] held_lift_r;
  logic               grip_open_r;
  logic [1:0]         track_r;
  logic [1:0]         action_r;
  logic               begin_r;

  // Mixer working registers.
  logic [CH_W-1:0]    ch_r [4];
  logic [1:0]         s1_r;
  logic signed [7:0]  v_r [4];
  logic [9:0]         q5_r;
  logic signed [13:0] cv_r [3];
  logic signed [15:0] w_r [4];
  logic [15:0]        peak_r;

  // Multiplier and serial divider.
  logic signed [30:0]  prod_r;
  logic [DIVR_W-1:0]   div_c_r;
  logic [MAG_W-1:0]    num_r;
  logic [DIVR_W-1:0]   rem_r;
  logic                neg_r;
  logic [CNT_W-1:0]    cnt_r;

  // Output register.
  logic               out_valid_r;
  logic signed [13:0] out_wheel_r [4];
  logic signed [10:0] out_grip_r;
  logic signed [15:0] out_lift_r;
  logic               out_open_r;
  logic [1:0]         out_action_r;
  logic [1:0]         out_track_r;
  logic               out_begin_r;
  logic               out_link_r;

  // Frame decode with neutral substitution on a lost link.
  logic [47:0]     bits_c;
  logic [CH_W-1:0] ch_c [4];
  logic [1:0]      s1_c;
  logic [1:0]      s2_c;
  logic            link_c;
  logic            valid_c;

  always_comb begin
    bits_c = {store_r[5], store_r[4], store_r[3], store_r[2], store_r[1], store_r[0]};
    link_c = quiet_r < timeout_r;
    valid_c = 1'b1;
    for (int i = 0; i < 4; i++) begin
      ch_c[i] = link_c ? bits_c[CH_W*i +: CH_W] : CH_W'(CH_MID);
      if (ch_c[i] < CH_W'(CH_LO) || ch_c[i] > CH_W'(CH_HI)) begin
        valid_c = 1'b0;
      end
    end
    s1_c = link_c ? bits_c[45:44] : S1_ARM;
    s2_c = link_c ? bits_c[47:46] : S2_MANUAL;
    if (s1_c == SW_OFF || s2_c == SW_OFF) begin
      valid_c = 1'b0;
    end
  end

  // Operand selection for the current arithmetic step.
  logic signed [15:0] op_a;
  logic signed [14:0] op_b;
  logic [DIVR_W-1:0]  op_c;
  logic signed [14:0] m_s;

  assign m_s = signed'({2'b0, max_rpm_r});

  always_comb begin
    op_a = '0;
    op_b = m_s;
    op_c = DIVR_W'(CURVE_DIV);
    unique case (step_r)
      ST_S0, ST_S1, ST_S2, ST_S3: begin
        op_a = signed'(16'(ch_r[step_r[1:0]])) - 16'(CH_MID);
        op_b = 15'(STICK_MUL);
        op_c = DIVR_W'(STICK_DIV);
      end
      ST_Q5: begin
        op_a = signed'({3'b0, max_rpm_r});
        op_b = 15'(FLAT_MUL);
        op_c = DIVR_W'(FLAT_DIV);
      end
      ST_CR: op_a = curve_arg(v_r[0]);
      ST_CH: op_a = curve_arg(v_r[2]);
      ST_CV: op_a = curve_arg(v_r[3]);
      ST_LIFT: begin
        op_a = -16'(v_r[3]);
        op_c = DIVR_W'(LIFT_DIV);
      end
      ST_LIFT70: begin
        op_a = held_lift_r;
        op_b = 15'(LIFT_UP);
        op_c = DIVR_W'(PCT_DIV);
      end
      ST_GRIP: op_a = 16'(v_r[1]);
      ST_W0, ST_W1, ST_W2, ST_W3: begin
        op_a = w_r[step_r[1:0] - 2'd3];
        op_c = peak_r;
      end
      default: op_a = '0;
    endcase
  end

  // Product, divider step and signed quotient.
  logic signed [30:0] prod_c;
  logic [DIVR_W:0]    rem_sh;
  logic               q_bit;
  logic signed [30:0] qmag;
  logic signed [30:0] q_c;
  logic signed [15:0] lift200_c;

  assign prod_c    = op_a * op_b;
  assign rem_sh    = {rem_r, num_r[MAG_W-1]};
  assign q_bit     = rem_sh >= {1'b0, div_c_r};
  assign qmag      = signed'({1'b0, num_r});
  assign q_c       = neg_r ? -qmag : qmag;
  assign lift200_c = signed'(q_c[15:0]) * 16'sd200;

  // Four-wheel mix and its peak magnitude.
  logic signed [15:0] w_c [4];
  logic signed [15:0] hh, vv, rr;
  logic [15:0]        peak_c;

  always_comb begin
    hh = 16'(cv_r[1]);
    vv = 16'(cv_r[2]);
    rr = 16'(cv_r[0]);
    for (int i = 0; i < 4; i++) begin
      w_c[i] = '0;
    end
    if (s1_r == S1_FWD) begin
      w_c[0] = hh + vv + rr;
      w_c[1] = hh - vv + rr;
      w_c[2] = -hh + vv + rr;
      w_c[3] = -hh - vv + rr;
    end else if (s1_r == S1_REV) begin
      w_c[0] = -hh - vv + rr;
      w_c[1] = -hh + vv + rr;
      w_c[2] = hh - vv + rr;
      w_c[3] = hh + vv + rr;
    end
    peak_c = '0;
    for (int i = 0; i < 4; i++) begin
      if (abs16(w_c[i]) > peak_c) begin
        peak_c = abs16(w_c[i]);
      end
    end
  end

  // Sequencer, state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= ST_S0;
      max_rpm_r   <= 13'd3600;
      timeout_r   <= 16'd1000;
      pos_r       <= '0;
      quiet_r     <= '0;
      link_r      <= 1'b0;
      held_grip_r <= '0;
      held_lift_r <= '0;
      grip_open_r <= 1'b0;
      track_r     <= '0;
      action_r    <= ACT_NONE;
      begin_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        held_wheel_r[i] <= '0;
      end
    end else begin
      // Configuration writes.
      if (cfg_we) begin
        if (cfg_index == CFG_MAX_RPM) begin
          max_rpm_r <= cfg_data[12:0];
        end else begin
          timeout_r <= cfg_data;
        end
      end

      // The result leaves on a transfer unless a new one replaces it.
      if (out_valid_r && out_ready && state_r != S_PUSH) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            unique case (cmd_t'(in_command))
              CMD_BYTE: begin
                if (pos_r < POS_W'(LIMIT_POS)) begin
                  if (pos_r < POS_W'(STORE_N)) begin
                    store_r[pos_r[2:0]] <= in_rx_byte;
                  end
                  pos_r <= pos_r + 1'b1;
                end
              end
              CMD_TICK: begin
                if (quiet_r != 16'hFFFF) begin
                  quiet_r <= quiet_r + 1'b1;
                end
              end
              CMD_END: begin
                pos_r    <= '0;
                link_r   <= link_c;
                action_r <= ACT_NONE;
                begin_r  <= 1'b0;
                if (!valid_c) begin
                  for (int i = 0; i < 4; i++) begin
                    held_wheel_r[i] <= '0;
                  end
                  state_r <= S_PUSH;
                end else begin
                  quiet_r <= '0;
                  if (s2_c == S2_MANUAL) begin
                    track_r[0]  <= 1'b0;
                    ch_r        <= ch_c;
                    s1_r        <= s1_c;
                    held_grip_r <= '0;
                    held_lift_r <= '0;
                    step_r      <= ST_S0;
                    state_r     <= S_MUL;
                  end else begin
                    begin_r <= !track_r[0];
                    track_r <= (s2_c == S2_LEFT) ? 2'b11 : 2'b01;
                    state_r <= S_PUSH;
                  end
                end
              end
              CMD_NONE: ;
              default: ;
            endcase
          end
        end

        S_MUL: begin
          prod_r  <= prod_c;
          div_c_r <= op_c;
          state_r <= S_LOAD;
        end

        S_LOAD: begin
          neg_r   <= prod_r[30];
          num_r   <= prod_r[30] ? MAG_W'(-prod_r) : prod_r[MAG_W-1:0];
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end

        // One quotient bit per cycle.
        S_DIV: begin
          rem_r <= q_bit ? DIVR_W'(rem_sh - {1'b0, div_c_r}) : rem_sh[DIVR_W-1:0];
          num_r <= {num_r[MAG_W-2:0], q_bit};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(MAG_W - 1)) begin
            state_r <= S_WB;
          end
        end

        S_WB: begin
          unique case (step_r)
            ST_S0, ST_S1, ST_S2: begin
              v_r[step_r[1:0]] <= signed'(q_c[7:0]);
              step_r  <= step_t'(step_r + 1'b1);
              state_r <= S_MUL;
            end
            ST_S3: begin
              v_r[3]  <= signed'(q_c[7:0]);
              step_r  <= ST_Q5;
              state_r <= S_MUL;
            end
            ST_Q5: begin
              q5_r    <= q_c[9:0];
              step_r  <= ST_CR;
              state_r <= S_MUL;
            end
            ST_CR: begin
              cv_r[0] <= shape_sel(v_r[0], q5_r, q_c);
              step_r  <= ST_CH;
              state_r <= S_MUL;
            end
            ST_CH: begin
              cv_r[1] <= shape_sel(v_r[2], q5_r, q_c);
              step_r  <= ST_CV;
              state_r <= S_MUL;
            end
            ST_CV: begin
              cv_r[2] <= shape_sel(v_r[3], q5_r, q_c);
              if (s1_r == S1_ARM) begin
                step_r  <= ST_LIFT;
                state_r <= S_MUL;
              end else begin
                state_r <= S_MIX;
              end
            end
            ST_LIFT: begin
              // Upward lift is scaled once more; downward only saturates.
              if (lift200_c > 16'sd0) begin
                held_lift_r <= lift200_c;
                step_r      <= ST_LIFT70;
              end else begin
                held_lift_r <= 16'(sat(31'(lift200_c), 31'(LIFT_LIM)));
                step_r      <= ST_GRIP;
              end
              state_r <= S_MUL;
            end
            ST_LIFT70: begin
              held_lift_r <= 16'(sat(q_c, 31'(LIFT_LIM)));
              step_r      <= ST_GRIP;
              state_r     <= S_MUL;
            end
            ST_GRIP: begin
              if (v_r[1] > 8'(GRIP_DEAD) || v_r[1] < -8'(GRIP_DEAD)) begin
                held_grip_r <= 11'(sat(q_c, 31'(GRIP_LIM)));
              end
              state_r <= S_MIX;
            end
            ST_W0, ST_W1, ST_W2: begin
              w_r[step_r[1:0] - 2'd3] <= q_c[15:0];
              step_r  <= step_t'(step_r + 1'b1);
              state_r <= S_MUL;
            end
            ST_W3: begin
              w_r[3]  <= q_c[15:0];
              state_r <= S_FIN;
            end
            default: state_r <= S_FIN;
          endcase
        end

        // Mix the wheels and decide on the peak limit.
        S_MIX: begin
          w_r    <= w_c;
          peak_r <= peak_c;
          if (peak_c > {3'b0, max_rpm_r}) begin
            step_r  <= ST_W0;
            state_r <= S_MUL;
          end else begin
            state_r <= S_FIN;
          end
        end

        // Commit wheels and the clamp toggle.
        S_FIN: begin
          for (int i = 0; i < 4; i++) begin
            held_wheel_r[i] <= w_r[i][13:0];
          end
          if (s1_r == S1_ARM) begin
            if (v_r[0] > 8'(CLAMP_TRIP) && !grip_open_r) begin
              grip_open_r <= 1'b1;
              action_r    <= ACT_PICK;
            end else if (v_r[0] < -8'(CLAMP_TRIP) && grip_open_r) begin
              grip_open_r <= 1'b0;
              action_r    <= ACT_DROP;
            end
          end
          state_r <= S_PUSH;
        end

        // Load the output register once it is free.
        S_PUSH: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_wheel_r  <= held_wheel_r;
            out_grip_r   <= held_grip_r;
            out_lift_r   <= held_lift_r;
            out_open_r   <= grip_open_r;
            out_action_r <= action_r;
            out_track_r  <= track_r;
            out_begin_r  <= begin_r;
            out_link_r   <= link_r;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_wheel0_speed = out_wheel_r[0];
  assign out_wheel1_speed = out_wheel_r[1];
  assign out_wheel2_speed = out_wheel_r[2];
  assign out_wheel3_speed = out_wheel_r[3];
  assign out_grip_speed   = out_grip_r;
  assign out_lift_speed   = out_lift_r;
  assign out_grip_open    = out_open_r;
  assign out_grip_action  = out_action_r;
  assign out_track_on     = out_track_r[0];
  assign out_track_left   = out_track_r[1];
  assign out_track_begin  = out_begin_r;
  assign out_link_up      = out_link_r;

endmodule

// File: hdl/rcdm_checker.sv
// Port-level checks of the drive mixer core, bound into the core module.
// Depends on rcdm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rcdm_checker import rcdm_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_command,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [13:0] out_wheel0_speed,
  input logic               out_grip_open,
  input logic [1:0]         out_grip_action,
  input logic               out_track_on,
  input logic               out_track_begin
);

  // A stalled result stays valid and keeps its wheel0 speed.
  `RCDM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_wheel0_speed), "stalled result changed")

  // A frame end transfer keeps the input closed in the next cycle.
  `RCDM_ASSERT_NXT(a_end_busy, in_valid && in_ready && in_command == CMD_END, !in_ready, "input open after frame end")

  // A pick up leaves the clamp open, a put down leaves it closed.
  `RCDM_ASSERT_IMP(a_pick_open, out_valid && out_grip_action == ACT_PICK, out_grip_open, "pick up with clamp closed")
  `RCDM_ASSERT_IMP(a_drop_closed, out_valid && out_grip_action == ACT_DROP, !out_grip_open, "put down with clamp open")

  // A tracking start shows tracking on and no clamp action.
  `RCDM_ASSERT_IMP(a_begin_on, out_valid && out_track_begin, out_track_on && out_grip_action == ACT_NONE, "tracking start inconsistent")

endmodule

bind rc_frame_to_drive_mixer_core rcdm_checker u_rcdm_checker (.*);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the drive mixer core: frames, ticks and register
// settings go in, and each frame-end result is compared with a built-in predictor.
// Depends on rcdm_pkg and rc_frame_to_drive_mixer_core.
module tb_top;
  import rcdm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_LEN    = 18;
  localparam int SETTLE       = 700;
  localparam int CYCLE_LIMIT  = 1000000;

  // One frame-end result as seen on the output channel.
  typedef struct packed {
    logic signed [13:0] wheel0;
    logic signed [13:0] wheel1;
    logic signed [13:0] wheel2;
    logic signed [13:0] wheel3;
    logic signed [10:0] grip;
    logic signed [15:0] lift;
    logic               grip_open;
    logic [1:0]         action;
    logic               track_on;
    logic               track_left;
    logic               track_begin;
    logic               link_up;
  } mix_result_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] in_command;
  logic [7:0] in_rx_byte;
  mix_result_t dut_res;
  logic cfg_we, cfg_index;
  logic [15:0] cfg_data;

  rc_frame_to_drive_mixer_core #(.FRAME_BYTES(FRAME_LEN)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_wheel0_speed(dut_res.wheel0), .out_wheel1_speed(dut_res.wheel1),
    .out_wheel2_speed(dut_res.wheel2), .out_wheel3_speed(dut_res.wheel3),
    .out_grip_speed(dut_res.grip), .out_lift_speed(dut_res.lift),
    .out_grip_open(dut_res.grip_open), .out_grip_action(dut_res.action),
    .out_track_on(dut_res.track_on), .out_track_left(dut_res.track_left),
    .out_track_begin(dut_res.track_begin), .out_link_up(dut_res.link_up),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state, mirroring the block's registers.
  int unsigned rpm_limit, quiet_limit;
  logic [7:0]  frame_bytes [STORE_N];
  int unsigned rx_count, quiet_ms;
  bit          link_ok, clamp_open, trk_on, trk_left;
  int          wheel_hold [4];
  int          grip_hold, lift_hold;

  mix_result_t expected_mix [$];
  int errors, items_sent, frames_sent, results_seen, cycles;
  int burst_left, hold_left;
  bit gaps_on;

  // Clock and cycle watchdog.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic int stick_val(input int raw);
    return (raw - CH_MID) * 5 / 33;
  endfunction

  function automatic int curve(input int v, input int m);
    int a;
    a = v < 0 ? -v : v;
    if (a < 5) return 0;
    if (a < 50) return v > 0 ? m * 5 / 100 : -(m * 5 / 100);
    if (v > 0) return (19 * v - 900) * m / 1000;
    return (19 * v + 900) * m / 1000;
  endfunction

  function automatic int limit_to(input int x, input int lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // Works out the result of one accepted transfer; returns 1 if one is due.
  function automatic bit predict_mix(input logic [1:0] cmd, input logic [7:0] b,
                                     output mix_result_t r);
    logic [47:0] bits;
    int c [4];
    int s1, s2, m, v0, v1, v2, v3, h, vv, rr, peak, grip, lift, a;
    int w [4];
    bit ok, begin_pulse;
    logic [1:0] act;
    r = '0;
    m = rpm_limit;
    begin_pulse = 0;
    act = ACT_NONE;
    if (cmd == CMD_BYTE) begin
      if (rx_count < FRAME_LEN) begin
        if (rx_count < STORE_N) frame_bytes[rx_count] = b;
        rx_count++;
      end
      return 0;
    end
    if (cmd == CMD_TICK) begin
      if (quiet_ms < 65535) quiet_ms++;
      return 0;
    end
    if (cmd != CMD_END) return 0;
    rx_count = 0;
    bits = {frame_bytes[5], frame_bytes[4], frame_bytes[3],
            frame_bytes[2], frame_bytes[1], frame_bytes[0]};
    for (int i = 0; i < 4; i++) c[i] = bits[11*i +: 11];
    s1 = bits[45:44];
    s2 = bits[47:46];
    link_ok = quiet_ms < quiet_limit;
    if (!link_ok) begin
      for (int i = 0; i < 4; i++) begin
        c[i] = CH_MID;
        wheel_hold[i] = 0;
      end
      s1 = S1_ARM;
      s2 = S2_MANUAL;
    end
    ok = (s1 != SW_OFF) && (s2 != SW_OFF);
    for (int i = 0; i < 4; i++) if (c[i] < CH_LO || c[i] > CH_HI) ok = 0;
    if (!ok) begin
      for (int i = 0; i < 4; i++) wheel_hold[i] = 0;
    end else begin
      v0 = stick_val(c[0]);
      v1 = stick_val(c[1]);
      v2 = stick_val(c[2]);
      v3 = stick_val(c[3]);
      quiet_ms = 0;
      if (s2 == S2_MANUAL) begin
        for (int i = 0; i < 4; i++) w[i] = 0;
        grip = 0;
        lift = 0;
        peak = 0;
        h = curve(v2, m);
        vv = curve(v3, m);
        rr = curve(v0, m);
        trk_on = 0;
        if (s1 == S1_FWD) begin
          w[0] = h + vv + rr;  w[1] = h - vv + rr;
          w[2] = -h + vv + rr; w[3] = -h - vv + rr;
        end else if (s1 == S1_REV) begin
          w[0] = -h - vv + rr; w[1] = -h + vv + rr;
          w[2] = h - vv + rr;  w[3] = h + vv + rr;
        end else begin
          lift = (-v3 * m / 8000) * 200;
          if (lift > 0) lift = lift * 70 / 100;
          lift = limit_to(lift, LIFT_LIM);
          if (v0 > 99 && !clamp_open) begin
            clamp_open = 1;
            act = ACT_PICK;
          end else if (v0 < -99 && clamp_open) begin
            clamp_open = 0;
            act = ACT_DROP;
          end
          if (v1 > 70 || v1 < -70) grip = limit_to(v1 * m / 1000, GRIP_LIM);
        end
        for (int i = 0; i < 4; i++) begin
          a = w[i] < 0 ? -w[i] : w[i];
          if (a > peak) peak = a;
        end
        if (peak > m) for (int i = 0; i < 4; i++) w[i] = w[i] * m / peak;
        for (int i = 0; i < 4; i++) wheel_hold[i] = w[i];
        grip_hold = grip;
        lift_hold = lift;
      end else begin
        begin_pulse = !trk_on;
        trk_on = 1;
        trk_left = (s2 == S2_LEFT);
      end
    end
    r.wheel0 = 14'(wheel_hold[0]);
    r.wheel1 = 14'(wheel_hold[1]);
    r.wheel2 = 14'(wheel_hold[2]);
    r.wheel3 = 14'(wheel_hold[3]);
    r.grip = 11'(grip_hold);
    r.lift = 16'(lift_hold);
    r.grip_open = clamp_open;
    r.action = act;
    r.track_on = trk_on;
    r.track_left = trk_left;
    r.track_begin = begin_pulse;
    r.link_up = link_ok;
    return 1;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("tb_top: result %0d field %s got %0d expected %0d",
             results_seen, field, got, want);
    errors++;
  endtask

  // Result checker: every output transfer against the oldest expectation.
  always @(posedge clk) begin
    mix_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_mix.size() == 0) begin
        $display("tb_top: unexpected result at cycle %0d", cycles);
        errors++;
      end else begin
        e = expected_mix.pop_front();
        if (dut_res.wheel0 !== e.wheel0) report_mismatch("wheel0", dut_res.wheel0, e.wheel0);
        if (dut_res.wheel1 !== e.wheel1) report_mismatch("wheel1", dut_res.wheel1, e.wheel1);
        if (dut_res.wheel2 !== e.wheel2) report_mismatch("wheel2", dut_res.wheel2, e.wheel2);
        if (dut_res.wheel3 !== e.wheel3) report_mismatch("wheel3", dut_res.wheel3, e.wheel3);
        if (dut_res.grip !== e.grip) report_mismatch("grip", dut_res.grip, e.grip);
        if (dut_res.lift !== e.lift) report_mismatch("lift", dut_res.lift, e.lift);
        if (dut_res.grip_open !== e.grip_open)
          report_mismatch("grip_open", dut_res.grip_open, e.grip_open);
        if (dut_res.action !== e.action) report_mismatch("action", dut_res.action, e.action);
        if (dut_res.track_on !== e.track_on)
          report_mismatch("track_on", dut_res.track_on, e.track_on);
        if (dut_res.track_left !== e.track_left)
          report_mismatch("track_left", dut_res.track_left, e.track_left);
        if (dut_res.track_begin !== e.track_begin)
          report_mismatch("track_begin", dut_res.track_begin, e.track_begin);
        if (dut_res.link_up !== e.link_up)
          report_mismatch("link_up", dut_res.link_up, e.link_up);
      end
      results_seen++;
    end
  end

  // Receiver: random ready pattern, long runs without stalls, and long hold-offs.
  initial begin
    int run_left;
    bit run_ready;
    run_left = 0;
    run_ready = 1;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        if (run_left == 0) begin
          if ($urandom_range(0, 5) == 0) begin
            run_ready = 1;
            run_left = $urandom_range(30, 80);
          end else begin
            run_ready = $urandom_range(0, 2) != 0;
            run_left = $urandom_range(1, 8);
          end
        end
        run_left--;
        out_ready = run_ready;
      end
    end
  end

  // Sends one transfer; called at a falling edge and returns at one.
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
    mix_result_t r;
    if (burst_left == 0) begin
      if (gaps_on) repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_valid = 1'b1;
    in_command = cmd;
    in_rx_byte = b;
    do @(posedge clk); while (!in_ready);
    if (predict_mix(cmd, b, r)) begin
      expected_mix.push_back(r);
      frames_sent++;
    end
    items_sent++;
    burst_left--;
    @(negedge clk);
    in_valid = 1'b0;
    in_command = 2'($urandom_range(0, 3));
    in_rx_byte = 8'($urandom_range(0, 255));
  endtask

  // Sends frame bytes for the given sticks and switches, then the frame end.
  task automatic send_frame(input int c0, input int c1, input int c2, input int c3,
                            input int s1, input int s2, input int n_bytes);
    logic [47:0] bits;
    bits = {2'(s2), 2'(s1), 11'(c3), 11'(c2), 11'(c1), 11'(c0)};
    for (int i = 0; i < n_bytes; i++)
      send_item(CMD_BYTE, i < STORE_N ? bits[8*i +: 8] : 8'($urandom_range(0, 255)));
    send_item(CMD_END, 8'($urandom_range(0, 255)));
  endtask

  // Waits until the block has drained, then lets its last work finish.
  task automatic wait_idle();
    while (expected_mix.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input int unsigned value);
    wait_idle();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = 16'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_MAX_RPM) rpm_limit = value & 16'h1FFF;
    else quiet_limit = value & 16'hFFFF;
  endtask

  function automatic int pick_channel();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 2047);
      1: return $urandom_range(0, 1) ? CH_LO : CH_HI;
      2: return $urandom_range(990, 1060);
      default: return $urandom_range(CH_LO, CH_HI);
    endcase
  endfunction

  function automatic int pick_switch();
    return $urandom_range(0, 12) == 0 ? 0 : $urandom_range(1, 3);
  endfunction

  // Directed: neutral, stick extremes, range errors, every mode, odd frames.
  task automatic test_directed();
    send_frame(CH_MID, CH_MID, CH_MID, CH_MID, S1_FWD, S2_MANUAL, 6);
    send_frame(CH_HI, CH_HI, CH_HI, CH_HI, S1_FWD, S2_MANUAL, 6);
    send_frame(CH_LO, CH_HI, CH_LO, CH_HI, S1_REV, S2_MANUAL, 6);
    send_frame(CH_LO - 1, CH_MID, CH_MID, CH_MID, S1_FWD, S2_MANUAL, 6);
    send_frame(CH_MID, 2047, CH_MID, CH_MID, S1_FWD, S2_MANUAL, 6);
    send_frame(CH_HI, CH_HI, CH_MID, CH_LO, S1_ARM, S2_MANUAL, 6);
    send_frame(CH_LO, CH_LO, CH_MID, CH_HI, S1_ARM, S2_MANUAL, 6);
    send_frame(CH_MID, CH_MID, CH_MID, CH_MID, SW_OFF, S2_MANUAL, 6);
    send_frame(CH_MID, CH_MID, CH_MID, CH_MID, S1_FWD, SW_OFF, 6);
    send_frame(CH_MID, CH_MID, CH_MID, CH_MID, S1_FWD, S2_LEFT, 6);
    send_frame(CH_MID, CH_MID, CH_MID, CH_MID, S1_FWD, S2_RIGHT, 6);
    // Long frame, unused command, short frame keeping earlier bytes.
    send_frame(0, CH_MID, CH_MID, CH_MID, S1_FWD, S2_MANUAL, FRAME_LEN + 3);
    send_item(CMD_NONE, 8'hFF);
    send_frame(CH_MID + 200, CH_MID, CH_MID, CH_MID, S1_REV, S2_MANUAL, 2);
  endtask

  // Link loss: ticks past two short timeouts, then the longest timeout.
  task automatic test_link_loss();
    write_reg(CFG_TIMEOUT, 1);
    send_item(CMD_TICK, 8'h00);
    send_frame(CH_HI, CH_MID, CH_MID, CH_MID, S1_FWD, S2_MANUAL, 6);
    send_frame(CH_HI, CH_MID, CH_HI, CH_MID, S1_FWD, S2_MANUAL, 6);
    write_reg(CFG_TIMEOUT, 3);
    repeat (5) send_item(CMD_TICK, 8'h00);
    send_frame(CH_LO, CH_MID, CH_MID, CH_MID, S1_ARM, S2_MANUAL, 6);
    write_reg(CFG_TIMEOUT, 65535);
  endtask

  // Output held off for a long stretch while frames keep coming.
  task automatic test_backpressure();
    hold_left = 1200;
    repeat (4)
      send_frame(pick_channel(), pick_channel(), pick_channel(), pick_channel(),
                 S1_FWD, S2_MANUAL, 6);
  endtask

  // Random frames, ticks and noise over several register settings.
  task automatic test_random();
    int unsigned rpm_set [5] = '{100, 8000, 0, 8191, 1500};
    int unsigned tmo_set [5] = '{40, 65535, 8, 1000, 20};
    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_MAX_RPM, rpm_set[p]);
      write_reg(CFG_TIMEOUT, tmo_set[p]);
      gaps_on = (p != 3);
      while (items_sent < 150 + 50 * (p + 1)) begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, 12)) send_item(CMD_TICK, 8'($urandom_range(0, 255)));
          1: send_item(CMD_NONE, 8'($urandom_range(0, 255)));
          2: send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
          default:
            send_frame(pick_channel(), pick_channel(), pick_channel(), pick_channel(),
                       pick_switch(), pick_switch(),
                       $urandom_range(0, 5) == 0 ? $urandom_range(0, FRAME_LEN + 4) : 6);
        endcase
      end
    end
  endtask

  // Test sequence.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_NONE;
    in_rx_byte = 8'h00;
    cfg_we = 1'b0;
    cfg_index = CFG_MAX_RPM;
    cfg_data = 16'h0000;
    errors = 0; items_sent = 0; frames_sent = 0; results_seen = 0; cycles = 0;
    burst_left = 0; hold_left = 0; gaps_on = 1;
    rpm_limit = 3600; quiet_limit = 1000;
    rx_count = 0; quiet_ms = 0; link_ok = 0; clamp_open = 0;
    trk_on = 0; trk_left = 0; grip_hold = 0; lift_hold = 0;
    for (int i = 0; i < 4; i++) wheel_hold[i] = 0;
    for (int i = 0; i < STORE_N; i++) frame_bytes[i] = 8'h00;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_link_loss();
    test_backpressure();
    test_random();
    wait_idle();

    $display("tb_top: %0d transfers in, %0d frame results checked, %0d mismatches",
             items_sent, results_seen, errors);
    $display("tb_top: covered all drive modes, range errors, link loss and stalls");
    if (errors == 0 && expected_mix.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
